// File: hdl/contiguous_first_fit_allocator_macros.svh
// ---------------------------------------------------------------------------
// Contiguous first-fit allocator assertion macros
// Concurrent checks on the clock, with reset masking.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIRST_FIT_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CFFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define CFFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define CFFA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CFFA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/cffa_pkg.sv
// ---------------------------------------------------------------------------
// Contiguous first-fit allocator package
// Field widths, word layout and parameter defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package cffa_pkg;

    localparam int NUM_BLOCKS_DEF     = 64;
    localparam int UNIT_PER_BLOCK_DEF = 4;

    localparam int SIZE_W   = 16;
    localparam int CFG_W    = 7;
    localparam int START_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int DIV_W    = SIZE_W + 1;
    localparam int STEP_W   = $clog2(DIV_W);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 7'd64;

endpackage

`default_nettype wire

// File: hdl/contiguous_first_fit_allocator.sv
// From accepted word to result word: a bit-serial divide, one map rotation to search,
// one rotation to mark and count. The next word is accepted the cycle after the result
// is queued, even while it waits.
// Reset (aresetn low, synchronous): map all free, blocks_in_use = 64.
// ---------------------------------------------------------------------------
// Contiguous first-fit allocator
// Serial search of a rotating block map for the lowest free run of blocks.
// ---------------------------------------------------------------------------
`default_nettype none

`include "contiguous_first_fit_allocator_macros.svh"

module contiguous_first_fit_allocator #(
    parameter int NUM_BLOCKS     = cffa_pkg::NUM_BLOCKS_DEF,
    parameter int UNIT_PER_BLOCK = cffa_pkg::UNIT_PER_BLOCK_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [cffa_pkg::CFG_W-1:0]     cfg_wr_data,   // blocks_in_use
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [cffa_pkg::S_TDATA_W-1:0] s_tdata,       // [15:0] request_size
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] granted, [6:1] start_block, [13:7] blocks_granted, [20:14] free_blocks,
    // [23:21] zero
    output logic [cffa_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int IW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int RW   = $clog2(NUM_BLOCKS + 1);
    localparam int NW   = cffa_pkg::DIV_W;
    localparam int UBW  = $clog2(UNIT_PER_BLOCK + 1);
    localparam int UBW1 = UBW + 1;
    localparam int PADW = cffa_pkg::M_TDATA_W - 1 - cffa_pkg::START_W - 2 * cffa_pkg::COUNT_W;

    localparam logic [UBW1-1:0] UPB_V    = UBW1'(UNIT_PER_BLOCK);
    localparam logic [NW-1:0]   ROUND_V  = NW'(UNIT_PER_BLOCK - 1);
    localparam logic [IW-1:0]   LAST_IDX = IW'(NUM_BLOCKS - 1);
    localparam logic [RW-1:0]   NB_V     = RW'(NUM_BLOCKS);
    localparam logic [cffa_pkg::STEP_W-1:0] LAST_STEP = cffa_pkg::STEP_W'(NW - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [cffa_pkg::CFG_W-1:0]      blocks_in_use_reg;
    logic [NUM_BLOCKS-1:0]           map_reg;
    logic [NUM_BLOCKS-1:0]           map_next;
    logic [NUM_BLOCKS:0]             map_ext;
    logic [NW-1:0]                   quot_reg;
    logic [UBW-1:0]                  rem_reg;
    logic [cffa_pkg::STEP_W-1:0]     step_reg;
    logic [IW-1:0]                   idx_reg;
    logic [RW-1:0]                   run_reg;
    logic [RW-1:0]                   free_reg;
    logic                            found_reg;
    logic [IW-1:0]                   start_reg;
    logic [IW-1:0]                   end_reg;
    logic                            m_tvalid_reg;
    logic [cffa_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic [RW-1:0]   range_w;
    logic            in_range;
    logic [UBW1-1:0] trial;
    logic            trial_ge;
    logic [UBW-1:0]  rem_next;
    logic            need_zero;
    logic            mark_hit;
    logic            new_bit;
    logic            out_free;

    assign range_w   = (int'(blocks_in_use_reg) > NUM_BLOCKS) ? NB_V
                                                               : RW'(blocks_in_use_reg);
    assign in_range  = RW'(idx_reg) < range_w;
    assign trial     = {rem_reg, quot_reg[NW-1]};
    assign trial_ge  = trial >= UPB_V;
    assign rem_next  = trial_ge ? UBW'(trial - UPB_V) : trial[UBW-1:0];
    assign need_zero = (quot_reg == '0);
    assign mark_hit  = found_reg && !need_zero && (idx_reg >= start_reg) && (idx_reg <= end_reg);
    assign new_bit   = map_reg[0] | ((state_reg == ST_MARK) && mark_hit);
    assign map_ext   = {new_bit, map_reg};
    assign map_next  = map_ext[NUM_BLOCKS:1];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            blocks_in_use_reg <= cffa_pkg::BLOCKS_IN_USE_RST;
            map_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                blocks_in_use_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        quot_reg  <= NW'(s_tdata[cffa_pkg::SIZE_W-1:0]) + ROUND_V;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[NW-2:0], trial_ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP) begin
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        found_reg <= 1'b0;
                        start_reg <= '0;
                        end_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    map_reg <= map_next;
                    if (in_range && !found_reg) begin
                        if (!map_reg[0]) begin
                            run_reg <= run_reg + 1'b1;
                            if (need_zero) begin
                                found_reg <= 1'b1;
                                start_reg <= idx_reg;
                                end_reg   <= idx_reg;
                            end else if (NW'(run_reg) + 1'b1 == quot_reg) begin
                                found_reg <= 1'b1;
                                start_reg <= IW'(NW'(idx_reg) + 1'b1 - quot_reg);
                                end_reg   <= idx_reg;
                            end
                        end else begin
                            run_reg <= '0;
                        end
                    end
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        free_reg  <= '0;
                        state_reg <= ST_MARK;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_MARK: begin
                    map_reg <= map_next;
                    if (in_range && !new_bit) begin
                        free_reg <= free_reg + 1'b1;
                    end
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {
                            PADW'(0),
                            cffa_pkg::COUNT_W'(free_reg),
                            found_reg ? cffa_pkg::COUNT_W'(quot_reg) : cffa_pkg::COUNT_W'(0),
                            found_reg ? cffa_pkg::START_W'(start_reg) : cffa_pkg::START_W'(0),
                            found_reg
                        };
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `CFFA_ASSERT_NXT(a_accept_starts_div, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DIV)
    `CFFA_ASSERT_IMP(a_refused_is_empty, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[13:1] == '0)
    `CFFA_ASSERT_IMP(a_free_within_range, aclk, aresetn, m_tvalid, int'(m_tdata[20:14]) <= int'(range_w))

endmodule

`default_nettype wire

// File: tb/sv/tb_contiguous_first_fit_allocator.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Contiguous first-fit allocator testbench
// Drives allocation requests and range settings through the stream and
// config ports, with random idling on both sides. A scoreboard keeps its
// own block map, predicts every result word and checks it field by field.
// ---------------------------------------------------------------------------

typedef struct {
    bit       granted;
    bit [5:0] start_block;
    bit [6:0] blocks_granted;
    bit [6:0] free_blocks;
} alloc_outcome_t;

class first_fit_tracker;
    bit [cffa_pkg::NUM_BLOCKS_DEF-1:0] occupied;
    bit [cffa_pkg::CFG_W-1:0]          blocks_in_use;
    alloc_outcome_t                    outcomes[$];
    int unsigned                       mismatches;

    function new();
        occupied      = '0;
        blocks_in_use = cffa_pkg::BLOCKS_IN_USE_RST;
        mismatches    = 0;
    endfunction

    function void set_range(bit [cffa_pkg::CFG_W-1:0] value);
        blocks_in_use = value;
    endfunction

    function int unsigned pending();
        return outcomes.size();
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("tb: %s mismatch: expected %0d, actual %0d", what, want, got);
        end
    endfunction

    function void place_request(bit [cffa_pkg::SIZE_W-1:0] size);
        int unsigned    need;
        int unsigned    range;
        int unsigned    free_cnt;
        int unsigned    j;
        int unsigned    k;
        bit             hit;
        bit             clear;
        alloc_outcome_t r;
        need = size / cffa_pkg::UNIT_PER_BLOCK_DEF;
        if (size % cffa_pkg::UNIT_PER_BLOCK_DEF != 0) begin
            need++;
        end
        range = (blocks_in_use > cffa_pkg::NUM_BLOCKS_DEF) ?
                cffa_pkg::NUM_BLOCKS_DEF : blocks_in_use;
        r   = '{default: 0};
        hit = 1'b0;
        for (j = 0; !hit && j < range && j + need <= range; j++) begin
            if (!occupied[j]) begin
                clear = 1'b1;
                for (k = j + 1; k < j + need; k++) begin
                    if (occupied[k]) begin
                        clear = 1'b0;
                    end
                end
                if (clear) begin
                    for (k = j; k < j + need; k++) begin
                        occupied[k] = 1'b1;
                    end
                    hit              = 1'b1;
                    r.start_block    = 6'(j);
                    r.blocks_granted = 7'(need);
                end
            end
        end
        r.granted = hit;
        free_cnt  = 0;
        for (j = 0; j < range; j++) begin
            if (!occupied[j]) begin
                free_cnt++;
            end
        end
        r.free_blocks = 7'(free_cnt);
        outcomes.push_back(r);
    endfunction

    function void check_result(logic [cffa_pkg::M_TDATA_W-1:0] word);
        alloc_outcome_t want;
        if (outcomes.size() == 0) begin
            report("unexpected word", 0, word);
        end else begin
            want = outcomes.pop_front();
            if (word[0] !== want.granted) begin
                report("granted", want.granted, word[0]);
            end
            if (word[6:1] !== want.start_block) begin
                report("start_block", want.start_block, word[6:1]);
            end
            if (word[13:7] !== want.blocks_granted) begin
                report("blocks_granted", want.blocks_granted, word[13:7]);
            end
            if (word[20:14] !== want.free_blocks) begin
                report("free_blocks", want.free_blocks, word[20:14]);
            end
        end
    endfunction
endclass

module tb_contiguous_first_fit_allocator;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * cffa_pkg::NUM_BLOCKS_DEF + cffa_pkg::DIV_W + 16;
    localparam int RANDOM_ITEMS = 1500;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [cffa_pkg::CFG_W-1:0]     cfg_wr_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cffa_pkg::S_TDATA_W-1:0] s_tdata;      // [15:0] request_size
    logic                           m_tvalid;
    logic                           m_tready;
    // [0] granted, [6:1] start_block, [13:7] blocks_granted, [20:14] free_blocks
    logic [cffa_pkg::M_TDATA_W-1:0] m_tdata;

    first_fit_tracker tracker     = new();
    bit               send_burst  = 1'b0;
    bit               take_burst  = 1'b0;
    int unsigned      idle_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    contiguous_first_fit_allocator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    function automatic int unsigned draw_gap(inout bit burst);
        if ($urandom_range(0, 29) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [cffa_pkg::SIZE_W-1:0] random_size();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            return '0;
        end else if (pick < 60) begin
            return cffa_pkg::SIZE_W'($urandom_range(1, 8));
        end else if (pick < 85) begin
            return cffa_pkg::SIZE_W'($urandom_range(9, 64));
        end else if (pick < 95) begin
            return cffa_pkg::SIZE_W'($urandom_range(65, 256));
        end
        return cffa_pkg::SIZE_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_request(input logic [cffa_pkg::SIZE_W-1:0] size);
        int unsigned gap;
        gap = draw_gap(send_burst);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= size;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.place_request(size);
    endtask

    task automatic write_range(input logic [cffa_pkg::CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_range(value);
    endtask

    initial begin
        int unsigned                sent;
        int unsigned                pick;
        int unsigned                cur_range;
        logic [cffa_pkg::CFG_W-1:0] phase_range;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty range: every request fails
        write_range(7'd0);
        send_request(16'd0);
        send_request(16'd1);
        send_request(16'hFFFF);

        write_range(7'd1);
        send_request(16'd0);
        send_request(16'd5);
        send_request(16'd3);
        send_request(16'd0);

        write_range(7'd8);
        send_request(16'd0);
        send_request(16'd4);
        send_request(16'd8);
        send_request(16'd24);
        send_request(16'd16);

        // above the map: acts as the full map
        write_range(7'd127);
        send_request(16'd256);
        send_request(16'd257);
        send_request(16'h8000);
        send_request(16'd9);
        send_request(16'd0);

        write_range(7'd64);
        send_request(16'h5555);
        send_request(16'h2AAA);
        send_request(16'd2);

        sent      = 0;
        cur_range = 13;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                phase_range = cffa_pkg::CFG_W'($urandom_range(65, 127));
            end else if (pick == 1) begin
                phase_range = cffa_pkg::CFG_W'($urandom_range(0, cur_range));
            end else begin
                cur_range   = cur_range + $urandom_range(0, 3);
                cur_range   = (cur_range > cffa_pkg::NUM_BLOCKS_DEF) ?
                              cffa_pkg::NUM_BLOCKS_DEF : cur_range;
                phase_range = cffa_pkg::CFG_W'(cur_range);
            end
            write_range(phase_range);
            repeat ($urandom_range(20, 80)) begin
                send_request(random_size());
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_contiguous_first_fit_allocator: done, clean");
        end else begin
            $display("tb_contiguous_first_fit_allocator: done, errors");
        end
        $finish;
    end

    initial begin
        int unsigned gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(take_burst);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            tracker.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_contiguous_first_fit_allocator: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
